### rtl/wrp_pkg.sv
`default_nettype none

package wrp_pkg;

   localparam int unsigned WRP_QUEUE_DEPTH = 4;

   localparam logic [31:0] TAG_RIFF     = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE     = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT      = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA     = 32'h6174_6164;
   localparam logic [31:0] MIN_FILE_LEN = 32'd44;
   localparam logic [31:0] FMT_MIN_LEN  = 32'd16;
   localparam logic [15:0] FMT_PCM      = 16'd1;
   localparam logic [15:0] MAX_BITS     = 16'd32;

   typedef enum logic [1:0] {
      EV_START = 2'd0,
      EV_FMT   = 2'd1,
      EV_FINAL = 2'd2
   } wrp_kind_type;

   typedef enum logic [1:0] {
      VERD_NONE   = 2'd0,
      VERD_ACCEPT = 2'd1,
      VERD_REJECT = 2'd2
   } wrp_verdict_type;

   typedef struct packed {
      logic        parse_status;
      logic        fmt_found;
      logic        data_found;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [5:0]  sample_bits;
      logic [31:0] data_offset;
      logic [31:0] data_length;
   } wrp_result_type;

   typedef struct packed {
      wrp_kind_type    kind;
      wrp_verdict_type verdict;
      logic            pre_bad;
      wrp_result_type  result;
   } wrp_event_type;

endpackage

`default_nettype wire

### rtl/wrp_if.sv
`default_nettype none

interface wrp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       file_start;

   modport source (output valid, output data_byte, output file_start, input ready);
   modport sink (input valid, input data_byte, input file_start, output ready);
endinterface

interface wrp_rsp_if;
   logic        valid;
   logic        ready;
   logic        parse_status;
   logic        fmt_found;
   logic        data_found;
   logic [15:0] channel_count;
   logic [31:0] sample_rate;
   logic [31:0] byte_rate;
   logic [15:0] block_align;
   logic [5:0]  sample_bits;
   logic [31:0] data_offset;
   logic [31:0] data_length;

   modport source (
      output valid, output parse_status, output fmt_found, output data_found,
      output channel_count, output sample_rate, output byte_rate, output block_align,
      output sample_bits, output data_offset, output data_length, input ready
   );
   modport sink (
      input valid, input parse_status, input fmt_found, input data_found,
      input channel_count, input sample_rate, input byte_rate, input block_align,
      input sample_bits, input data_offset, input data_length, output ready
   );
endinterface

`default_nettype wire

### rtl/wrp_front.sv
`default_nettype none

module wrp_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [31:0]            csr_wr_data,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [7:0]             data_byte,
   input  logic                   file_start,
   output logic                   ev_valid,
   input  logic                   ev_ready,
   output wrp_pkg::wrp_event_type ev_item
);
   import wrp_pkg::*;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_RIFF = 6'b000010,
      PH_CHDR = 6'b000100,
      PH_FMT  = 6'b001000,
      PH_SKIP = 6'b010000,
      PH_DONE = 6'b100000
   } wrp_phase_type;

   localparam logic [31:0] RIFF_LEN_BYTE = 32'd7;
   localparam logic [31:0] RIFF_END_BYTE = 32'd11;
   localparam logic [4:0]  HDR_LAST      = 5'd7;
   localparam logic [4:0]  FMT_MID       = 5'd15;
   localparam logic [4:0]  FMT_LAST      = 5'd23;
   localparam logic [32:0] FIRST_CHUNK   = 33'd12;

   wrp_phase_type phase_ff, phase_in;
   logic [31:0] file_len_ff, file_len_in;
   logic [31:0] idx_ff, idx_in;
   logic [32:0] nco_ff, nco_in;
   logic [55:0] shift_ff, shift_in;
   logic [4:0]  cpos_ff, cpos_in;
   logic [31:0] cur_len_ff, cur_len_in;
   logic [31:0] riff_ff, riff_in;
   logic [15:0] chan_ff, chan_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] align_ff, align_in;
   logic [5:0]  bits_ff, bits_in;
   logic [31:0] doff_ff, doff_in;
   logic [31:0] dlen_ff, dlen_in;
   logic        fmt_seen_ff, fmt_seen_in;
   logic        data_seen_ff, data_seen_in;
   logic        err_ff, err_in;

   logic        accept;
   logic        do_adv;
   logic [63:0] shift_new;
   logic [31:0] hdr_id;
   logic [31:0] hdr_len;
   logic [31:0] adv_len;
   logic [34:0] size_x;
   logic [34:0] np_raw;
   logic [34:0] np;
   logic        adv_end;
   logic        adv_rej;
   logic        hdr_over;
   logic        fmt_cut;
   logic [31:0] riff_adj;
   logic        riff_bad;
   logic [15:0] fmt_bits;
   logic        fmt_pre_bad;
   logic [32:0] data_pos;

   assign shift_new   = {data_byte, shift_ff};
   assign hdr_id      = shift_new[31:0];
   assign hdr_len     = shift_new[63:32];
   assign adv_len     = (phase_ff == PH_FMT) ? cur_len_ff : hdr_len;
   assign size_x      = {3'b000, file_len_ff};
   assign np_raw      = {2'b00, nco_ff} + {3'b000, adv_len} + 35'd8;
   assign np          = np_raw + {34'd0, np_raw[0]};
   assign adv_end     = np >= size_x;
   assign adv_rej     = (np + 35'd8) > size_x;
   assign hdr_over    = ({2'b00, nco_ff} + {3'b000, hdr_len} + 35'd4) > size_x;
   assign fmt_cut     = ({2'b00, nco_ff} + 35'd24) > size_x;
   assign riff_adj    = riff_ff + {31'd0, riff_ff[0]};
   assign riff_bad    = ({1'b0, riff_adj} + 33'd8) != {1'b0, file_len_ff};
   assign fmt_bits    = shift_new[63:48];
   assign fmt_pre_bad = err_ff || (chan_ff == 16'd0) || (fmt_bits[2:0] != 3'd0) ||
                        (fmt_bits > MAX_BITS);
   assign data_pos    = nco_ff + 33'd8;

   assign in_ready = ev_ready;
   assign accept   = in_valid && in_ready;

   always_comb begin
      phase_in     = phase_ff;
      file_len_in  = csr_wr_en ? csr_wr_data : file_len_ff;
      idx_in       = idx_ff;
      nco_in       = nco_ff;
      shift_in     = shift_ff;
      cpos_in      = cpos_ff;
      cur_len_in   = cur_len_ff;
      riff_in      = riff_ff;
      chan_in      = chan_ff;
      rate_in      = rate_ff;
      brate_in     = brate_ff;
      align_in     = align_ff;
      bits_in      = bits_ff;
      doff_in      = doff_ff;
      dlen_in      = dlen_ff;
      fmt_seen_in  = fmt_seen_ff;
      data_seen_in = data_seen_ff;
      err_in       = err_ff;
      do_adv       = 1'b0;
      ev_valid        = 1'b0;
      ev_item.kind    = EV_FINAL;
      ev_item.verdict = VERD_NONE;
      ev_item.pre_bad = 1'b0;

      if (accept) begin
         if (file_start) begin
            phase_in     = PH_RIFF;
            idx_in       = '0;
            nco_in       = FIRST_CHUNK;
            cpos_in      = '0;
            cur_len_in   = '0;
            riff_in      = '0;
            chan_in      = '0;
            rate_in      = '0;
            brate_in     = '0;
            align_in     = '0;
            bits_in      = '0;
            doff_in      = '0;
            dlen_in      = '0;
            fmt_seen_in  = 1'b0;
            data_seen_in = 1'b0;
            err_in       = 1'b0;
            ev_valid     = 1'b1;
            ev_item.kind = EV_START;
            if (file_len_ff < MIN_FILE_LEN) begin
               ev_item.verdict = VERD_REJECT;
               phase_in        = PH_DONE;
            end
         end

         if (phase_in == PH_SKIP && {1'b0, idx_in} == nco_in) begin
            phase_in = PH_CHDR;
            cpos_in  = '0;
         end

         if (phase_in != PH_IDLE && phase_in != PH_DONE) begin
            shift_in = shift_new[63:8];
            case (phase_in)
               PH_RIFF: begin
                  if (idx_in == RIFF_LEN_BYTE) begin
                     if (shift_new[31:0] != TAG_RIFF) begin
                        err_in = 1'b1;
                     end
                     riff_in = shift_new[63:32];
                  end else if (idx_in == RIFF_END_BYTE) begin
                     if (err_ff || shift_new[63:32] != TAG_WAVE || riff_bad) begin
                        ev_valid        = 1'b1;
                        ev_item.verdict = VERD_REJECT;
                        phase_in        = PH_DONE;
                     end else begin
                        nco_in   = FIRST_CHUNK;
                        phase_in = PH_CHDR;
                        cpos_in  = '0;
                     end
                  end
               end
               PH_CHDR: begin
                  if (cpos_in == HDR_LAST) begin
                     if (hdr_over) begin
                        ev_valid        = 1'b1;
                        ev_item.verdict = VERD_REJECT;
                        phase_in        = PH_DONE;
                     end else if (hdr_id == TAG_FMT) begin
                        if (fmt_seen_ff || hdr_len < FMT_MIN_LEN || fmt_cut) begin
                           ev_valid        = 1'b1;
                           ev_item.verdict = VERD_REJECT;
                           phase_in        = PH_DONE;
                        end else begin
                           cur_len_in = hdr_len;
                           phase_in   = PH_FMT;
                        end
                     end else if (hdr_id == TAG_DATA && data_seen_ff) begin
                        ev_valid        = 1'b1;
                        ev_item.verdict = VERD_REJECT;
                        phase_in        = PH_DONE;
                     end else begin
                        if (hdr_id == TAG_DATA) begin
                           data_seen_in = 1'b1;
                           doff_in      = data_pos[31:0];
                           dlen_in      = hdr_len;
                        end
                        do_adv = 1'b1;
                     end
                  end
                  cpos_in = cpos_in + 5'd1;
               end
               PH_FMT: begin
                  if (cpos_in == FMT_MID) begin
                     if (shift_new[15:0] != FMT_PCM) begin
                        err_in = 1'b1;
                     end
                     chan_in = shift_new[31:16];
                     rate_in = shift_new[63:32];
                  end else if (cpos_in == FMT_LAST) begin
                     brate_in        = shift_new[31:0];
                     align_in        = shift_new[47:32];
                     bits_in         = fmt_bits[5:0];
                     fmt_seen_in     = 1'b1;
                     ev_valid        = 1'b1;
                     ev_item.kind    = EV_FMT;
                     ev_item.pre_bad = fmt_pre_bad;
                     do_adv          = 1'b1;
                  end
                  cpos_in = cpos_in + 5'd1;
               end
               default: begin
               end
            endcase

            if (do_adv) begin
               if (adv_end) begin
                  ev_valid        = 1'b1;
                  ev_item.verdict = VERD_ACCEPT;
                  phase_in        = PH_DONE;
               end else if (adv_rej) begin
                  ev_valid        = 1'b1;
                  ev_item.verdict = VERD_REJECT;
                  phase_in        = PH_DONE;
               end else begin
                  nco_in   = np[32:0];
                  phase_in = PH_SKIP;
               end
            end
            idx_in = idx_in + 32'd1;
         end
      end

      ev_item.result.parse_status  = 1'b0;
      ev_item.result.fmt_found     = fmt_seen_in;
      ev_item.result.data_found    = data_seen_in;
      ev_item.result.channel_count = chan_in;
      ev_item.result.sample_rate   = rate_in;
      ev_item.result.byte_rate     = brate_in;
      ev_item.result.block_align   = align_in;
      ev_item.result.sample_bits   = bits_in;
      ev_item.result.data_offset   = doff_in;
      ev_item.result.data_length   = dlen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         file_len_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         file_len_ff <= file_len_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      nco_ff       <= nco_in;
      shift_ff     <= shift_in;
      cpos_ff      <= cpos_in;
      cur_len_ff   <= cur_len_in;
      riff_ff      <= riff_in;
      chan_ff      <= chan_in;
      rate_ff      <= rate_in;
      brate_ff     <= brate_in;
      align_ff     <= align_in;
      bits_ff      <= bits_in;
      doff_ff      <= doff_in;
      dlen_ff      <= dlen_in;
      fmt_seen_ff  <= fmt_seen_in;
      data_seen_ff <= data_seen_in;
      err_ff       <= err_in;
   end

endmodule

`default_nettype wire

### rtl/wrp_queue.sv
`default_nettype none

module wrp_queue #(
   parameter int unsigned DEPTH = wrp_pkg::WRP_QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  wrp_pkg::wrp_event_type in_item,
   output logic                   out_valid,
   input  logic                   out_ready,
   output wrp_pkg::wrp_event_type out_item
);
   import wrp_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   wrp_event_type    slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = count_ff != FULL_CNT;
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

`default_nettype wire

### rtl/wrp_back.sv
`default_nettype none

module wrp_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    ev_valid,
   output logic                    ev_ready,
   input  wrp_pkg::wrp_event_type  ev_item,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output wrp_pkg::wrp_result_type rsp_item
);
   import wrp_pkg::*;

   typedef enum logic [3:0] {
      BK_IDLE  = 4'b0001,
      BK_MUL1  = 4'b0010,
      BK_MUL2  = 4'b0100,
      BK_CHECK = 4'b1000
   } wrp_back_state_type;

   wrp_back_state_type state_ff, state_in;
   logic           drop_ff, drop_in;
   wrp_event_type  hold_ff, hold_in;
   logic [31:0]    rate_ch_ff, rate_ch_in;
   logic [21:0]    align_prod_ff, align_prod_in;
   logic [31:0]    byte_prod_ff, byte_prod_in;
   logic           out_valid_ff, out_valid_in;
   wrp_result_type out_ff, out_in;

   logic           slot_free;
   logic           pop;
   logic           fmt_bad;
   logic           emit;
   logic           emit_reject;

   assign slot_free = !out_valid_ff || rsp_ready;
   assign ev_ready  = (state_ff == BK_IDLE) && slot_free;
   assign pop       = ev_valid && ev_ready;

   assign rate_ch_in    = hold_ff.result.sample_rate * 32'(hold_ff.result.channel_count);
   assign align_prod_in = 22'(hold_ff.result.channel_count) * 22'(hold_ff.result.sample_bits);
   assign byte_prod_in  = rate_ch_ff * 32'(hold_ff.result.sample_bits);

   assign fmt_bad = hold_ff.pre_bad ||
                    (hold_ff.result.byte_rate != {3'b000, byte_prod_ff[31:3]}) ||
                    ({3'b000, hold_ff.result.block_align} != align_prod_ff[21:3]);

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   always_comb begin
      state_in    = state_ff;
      drop_in     = drop_ff;
      hold_in     = hold_ff;
      emit        = 1'b0;
      emit_reject = 1'b0;

      case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               case (ev_item.kind)
                  EV_START: begin
                     drop_in     = 1'b0;
                     emit        = ev_item.verdict == VERD_REJECT;
                     emit_reject = 1'b1;
                  end
                  EV_FMT: begin
                     if (!drop_ff) begin
                        hold_in  = ev_item;
                        state_in = BK_MUL1;
                     end
                  end
                  EV_FINAL: begin
                     emit        = !drop_ff && ev_item.verdict != VERD_NONE;
                     emit_reject = ev_item.verdict == VERD_REJECT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_MUL1: begin
            state_in = BK_MUL2;
         end
         BK_MUL2: begin
            state_in = BK_CHECK;
         end
         BK_CHECK: begin
            if (slot_free) begin
               state_in = BK_IDLE;
               if (fmt_bad) begin
                  emit        = 1'b1;
                  emit_reject = 1'b1;
                  drop_in     = 1'b1;
               end else begin
                  emit        = hold_ff.verdict != VERD_NONE;
                  emit_reject = hold_ff.verdict == VERD_REJECT;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         if (emit_reject) begin
            out_in              = '0;
            out_in.parse_status = 1'b1;
         end else begin
            out_in              = (state_ff == BK_IDLE) ? ev_item.result : hold_ff.result;
            out_in.parse_status = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         drop_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         drop_ff      <= drop_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff       <= hold_in;
      rate_ch_ff    <= rate_ch_in;
      align_prod_ff <= align_prod_in;
      byte_prod_ff  <= byte_prod_in;
      out_ff        <= out_in;
   end

`ifndef ASSERT_OFF
   a_mul_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_MUL2 |-> $past(state_ff) == BK_MUL1)
      else $error("second multiply step entered out of order");

   a_fmt_start: assert property (@(posedge clock) disable iff (reset)
      pop && ev_item.kind == EV_FMT && !drop_ff |=> state_ff == BK_MUL1)
      else $error("fmt check did not start after pop");

   a_reject_clean: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.parse_status |->
         !out_ff.fmt_found && !out_ff.data_found &&
         out_ff.channel_count == 16'd0 && out_ff.data_length == 32'd0)
      else $error("rejected result carries field data");

   a_fmt_sane: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.parse_status && out_ff.fmt_found |->
         out_ff.channel_count != 16'd0 && out_ff.sample_bits[2:0] == 3'd0 &&
         out_ff.sample_bits <= 6'd32)
      else $error("accepted fmt fields break the fmt rules");
`endif

endmodule

`default_nettype wire

### rtl/wav_riff_header_parser.sv
// Channel  Dir  Handshake     Payload
// req_if   in   valid/ready   data_byte[7:0], file_start
// rsp_if   out  valid/ready   parse_status, fmt_found, data_found, fmt fields, data offset/length
// csr      in   csr_wr_en     csr_wr_data[31:0] -> file_length
//
// One byte per cycle is taken while the event queue (QUEUE_DEPTH entries) has room.
// A verdict passes the event queue and the back end's output register to reach rsp_if; the
// byte that closes the fmt chunk also passes the back end's two multiply steps and compare.
// Reset clears the parse phase, the queue, the back end and file_length.
// A stalled result holds the back end; the front keeps taking bytes until the queue fills.
`default_nettype none

module wav_riff_header_parser #(
   parameter int unsigned QUEUE_DEPTH = wrp_pkg::WRP_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,
   wrp_req_if.sink     req_if,
   wrp_rsp_if.source   rsp_if
);
   import wrp_pkg::*;

   logic           fe_valid;
   logic           fe_ready;
   wrp_event_type  fe_item;
   logic           be_valid;
   logic           be_ready;
   wrp_event_type  be_item;
   wrp_result_type rsp_item;

   wrp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (req_if.valid),
      .in_ready    (req_if.ready),
      .data_byte   (req_if.data_byte),
      .file_start  (req_if.file_start),
      .ev_valid    (fe_valid),
      .ev_ready    (fe_ready),
      .ev_item     (fe_item)
   );

   wrp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_ready  (fe_ready),
      .in_item   (fe_item),
      .out_valid (be_valid),
      .out_ready (be_ready),
      .out_item  (be_item)
   );

   wrp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .ev_valid  (be_valid),
      .ev_ready  (be_ready),
      .ev_item   (be_item),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .rsp_item  (rsp_item)
   );

   assign rsp_if.parse_status  = rsp_item.parse_status;
   assign rsp_if.fmt_found     = rsp_item.fmt_found;
   assign rsp_if.data_found    = rsp_item.data_found;
   assign rsp_if.channel_count = rsp_item.channel_count;
   assign rsp_if.sample_rate   = rsp_item.sample_rate;
   assign rsp_if.byte_rate     = rsp_item.byte_rate;
   assign rsp_if.block_align   = rsp_item.block_align;
   assign rsp_if.sample_bits   = rsp_item.sample_bits;
   assign rsp_if.data_offset   = rsp_item.data_offset;
   assign rsp_if.data_length   = rsp_item.data_length;

endmodule

`default_nettype wire

### bench/tb_wav_riff_header_parser.sv
`default_nettype none

module tb_wav_riff_header_parser;
   timeunit 1ns;
   timeprecision 1ps;

   import wrp_pkg::*;

   localparam int unsigned ITEM_TARGET = 1600;
   localparam int unsigned QUIET_LIMIT = 3000;
   localparam int unsigned SETTLE_CYCLES = 12;

   typedef enum logic [2:0] {
      ST_WAIT,
      ST_HEAD,
      ST_CHUNK_HDR,
      ST_FMT_BODY,
      ST_SKIP,
      ST_DONE
   } walk_state_type;

   typedef enum int {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_PATTERN
   } ready_mode_type;

   typedef enum int {
      WF_PLAIN,
      WF_DATA_FIRST,
      WF_TWO_FMT,
      WF_TWO_DATA,
      WF_BAD_FMT,
      WF_DATA_ONLY,
      WF_FMT_ONLY,
      WF_HUGE_DATA,
      WF_EXTRA_CHUNKS
   } wave_shape_type;

   typedef struct packed {
      logic [7:0] data;
      logic       start;
   } byte_item_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   wrp_req_if req_if();
   wrp_rsp_if rsp_if();

   wav_riff_header_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_if     (req_if),
      .rsp_if     (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // header walker state
   walk_state_type walk = ST_WAIT;
   logic [31:0]    file_len = '0;
   logic [31:0]    byte_pos = '0;
   logic [63:0]    chunk_at = 64'd12;
   logic [63:0]    shreg = '0;
   logic [31:0]    fmt_len = '0;
   logic [31:0]    riff_len = '0;
   logic [15:0]    h_chan = '0;
   logic [31:0]    h_rate = '0;
   logic [31:0]    h_brate = '0;
   logic [15:0]    h_align = '0;
   logic [15:0]    h_bits = '0;
   logic [31:0]    h_doff = '0;
   logic [31:0]    h_dlen = '0;
   logic [2:0]     seen = '0;

   wrp_result_type verdict_q[$];
   wrp_result_type want_r;
   byte_item_type  pending_q[$];
   byte_item_type  nxt;
   logic [7:0]     img[$];

   int unsigned bytes_queued = 0;
   int unsigned bytes_taken = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int unsigned burst_left = 0;
   int unsigned gap_left = 0;
   int unsigned ready_span = 0;
   ready_mode_type ready_mode = RDY_ALWAYS;
   logic [31:0] stall_mask = '1;
   bit          byte_taken = 1'b0;

   function automatic void clear_file();
      byte_pos = '0;
      chunk_at = 64'd12;
      shreg = '0;
      fmt_len = '0;
      riff_len = '0;
      h_chan = '0;
      h_rate = '0;
      h_brate = '0;
      h_align = '0;
      h_bits = '0;
      h_doff = '0;
      h_dlen = '0;
      seen = '0;
   endfunction

   function automatic void close_file(bit reject);
      wrp_result_type r;
      r = '0;
      r.parse_status = reject;
      if (!reject) begin
         r.fmt_found = seen[0];
         r.data_found = seen[1];
         r.channel_count = h_chan;
         r.sample_rate = h_rate;
         r.byte_rate = h_brate;
         r.block_align = h_align;
         r.sample_bits = h_bits[5:0];
         r.data_offset = h_doff;
         r.data_length = h_dlen;
      end
      walk = ST_DONE;
      verdict_q.push_back(r);
   endfunction

   function automatic void step_chunk(logic [31:0] len);
      logic [63:0] np;
      np = chunk_at + 64'(len) + 64'd8;
      if (np[0]) np = np + 64'd1;
      if (np >= 64'(file_len)) begin
         close_file(1'b0);
      end else if (np + 64'd8 > 64'(file_len)) begin
         close_file(1'b1);
      end else begin
         chunk_at = np;
         walk = ST_SKIP;
      end
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic st);
      logic [63:0] flen64, pos, k, want, br;
      logic [31:0] id, len, ch, bits, align, radj;
      bit          bad;
      flen64 = 64'(file_len);
      if (st) begin
         clear_file();
         walk = ST_HEAD;
         if (flen64 < 64'(MIN_FILE_LEN)) begin
            close_file(1'b1);
            return;
         end
      end
      if (walk == ST_WAIT || walk == ST_DONE) return;
      if (walk == ST_SKIP && 64'(byte_pos) == chunk_at) walk = ST_CHUNK_HDR;
      shreg = {b, shreg[63:8]};
      if (walk == ST_HEAD) begin
         if (byte_pos == 32'd7) begin
            if (shreg[31:0] != TAG_RIFF) seen[2] = 1'b1;
            riff_len = shreg[63:32];
         end else if (byte_pos == 32'd11) begin
            radj = riff_len + 32'(riff_len[0]);
            want = 64'(radj) + 64'd8;
            bad = seen[2] || shreg[63:32] != TAG_WAVE || want != flen64;
            if (bad) begin
               close_file(1'b1);
               return;
            end
            chunk_at = 64'd12;
            walk = ST_CHUNK_HDR;
         end
      end else if (walk == ST_CHUNK_HDR || walk == ST_FMT_BODY) begin
         pos = chunk_at;
         k = 64'(byte_pos) - pos;
         if (walk == ST_CHUNK_HDR && k == 64'd7) begin
            id = shreg[31:0];
            len = shreg[63:32];
            if (64'(len) + pos + 64'd4 > flen64) begin
               close_file(1'b1);
               return;
            end
            if (id == TAG_FMT) begin
               if (seen[0] || len < FMT_MIN_LEN || pos + 64'd24 > flen64) begin
                  close_file(1'b1);
                  return;
               end
               fmt_len = len;
               walk = ST_FMT_BODY;
            end else begin
               if (id == TAG_DATA) begin
                  if (seen[1]) begin
                     close_file(1'b1);
                     return;
                  end
                  seen[1] = 1'b1;
                  h_doff = 32'(pos + 64'd8);
                  h_dlen = len;
               end
               step_chunk(len);
            end
         end else if (walk == ST_FMT_BODY && k == 64'd15) begin
            if (shreg[15:0] != FMT_PCM) seen[2] = 1'b1;
            h_chan = shreg[31:16];
            h_rate = shreg[63:32];
         end else if (walk == ST_FMT_BODY && k == 64'd23) begin
            ch = 32'(h_chan);
            align = 32'(shreg[47:32]);
            bits = 32'(shreg[63:48]);
            h_brate = shreg[31:0];
            h_align = shreg[47:32];
            h_bits = shreg[63:48];
            br = (64'(h_rate) * 64'(ch)) & 64'hFFFF_FFFF;
            br = ((br * 64'(bits)) & 64'hFFFF_FFFF) / 64'd8;
            bad = seen[2] || ch == 0 || 64'(h_brate) != br ||
                  64'(align) != (64'(ch) * 64'(bits)) / 64'd8 ||
                  (bits % 32'd8) != 0 || bits > 32'(MAX_BITS);
            if (bad) begin
               close_file(1'b1);
               return;
            end
            seen[0] = 1'b1;
            step_chunk(fmt_len);
         end
      end
      byte_pos = byte_pos + 32'd1;
   endfunction

   function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endfunction

   // sample both channels and the register port
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (csr_wr_en) file_len = csr_wr_data;
         if (rsp_if.valid && rsp_if.ready) begin
            if (verdict_q.size() == 0) begin
               $error("result with no item pending: status %0b", rsp_if.parse_status);
               mismatches++;
            end else begin
               want_r = verdict_q.pop_front();
               cmp_field("parse_status", 32'(want_r.parse_status),
                         32'(rsp_if.parse_status));
               cmp_field("fmt_found", 32'(want_r.fmt_found), 32'(rsp_if.fmt_found));
               cmp_field("data_found", 32'(want_r.data_found), 32'(rsp_if.data_found));
               cmp_field("channel_count", 32'(want_r.channel_count),
                         32'(rsp_if.channel_count));
               cmp_field("sample_rate", want_r.sample_rate, rsp_if.sample_rate);
               cmp_field("byte_rate", want_r.byte_rate, rsp_if.byte_rate);
               cmp_field("block_align", 32'(want_r.block_align), 32'(rsp_if.block_align));
               cmp_field("sample_bits", 32'(want_r.sample_bits), 32'(rsp_if.sample_bits));
               cmp_field("data_offset", want_r.data_offset, rsp_if.data_offset);
               cmp_field("data_length", want_r.data_length, rsp_if.data_length);
            end
         end
         if (req_if.valid && req_if.ready) begin
            parse_byte(req_if.data_byte, req_if.file_start);
            bytes_taken++;
            byte_taken = 1'b1;
         end
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // send bytes in bursts with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data_byte <= '0;
         req_if.file_start <= 1'b0;
      end else if (!req_if.valid || byte_taken) begin
         byte_taken = 1'b0;
         if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         end
         if (gap_left != 0 || pending_q.size() == 0) begin
            if (gap_left != 0) gap_left--;
            req_if.valid <= 1'b0;
         end else begin
            nxt = pending_q.pop_front();
            req_if.valid <= 1'b1;
            req_if.data_byte <= nxt.data;
            req_if.file_start <= nxt.start;
            burst_left--;
         end
      end
   end

   // stall the result channel
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (ready_span == 0) begin
            ready_span = $urandom_range(1, 64);
            ready_mode = ready_mode_type'($urandom_range(0, 2));
            stall_mask = $urandom;
         end
         ready_span--;
         case (ready_mode)
            RDY_ALWAYS: rsp_if.ready <= 1'b1;
            RDY_COIN: rsp_if.ready <= 1'($urandom_range(0, 1));
            default: begin
               rsp_if.ready <= stall_mask[0];
               stall_mask = {stall_mask[0], stall_mask[31:1]};
            end
         endcase
      end
   end

   function automatic void queue_byte(logic [7:0] d, logic s);
      byte_item_type it;
      it.data = d;
      it.start = s;
      pending_q.push_back(it);
      bytes_queued++;
   endfunction

   function automatic void queue_file(int unsigned n);
      for (int unsigned i = 0; i < n; i++) queue_byte(img[i], i == 0);
   endfunction

   function automatic void put_le(logic [31:0] v, int nbytes);
      for (int i = 0; i < nbytes; i++) img.push_back(v[8*i +: 8]);
   endfunction

   function automatic void fill(int unsigned n);
      for (int unsigned i = 0; i < n; i++) img.push_back(8'($urandom));
   endfunction

   function automatic void put_fmt(bit sound);
      logic [15:0] fmt_code, ch, align, bits;
      logic [31:0] rate, brate, body;
      logic [63:0] prod;
      fmt_code = FMT_PCM;
      ch = 16'($urandom_range(1, 8));
      bits = 16'(8 * $urandom_range(0, 4));
      rate = $urandom_range(0, 1) ? $urandom : $urandom_range(8000, 96000);
      if (!sound) begin
         case ($urandom_range(0, 5))
            0: fmt_code = 16'($urandom_range(0, 3));
            1: ch = '0;
            2: ch = 16'($urandom);
            3: bits = 16'($urandom_range(0, 40));
            default: ;
         endcase
      end
      prod = (64'(rate) * 64'(ch)) & 64'hFFFF_FFFF;
      prod = ((prod * 64'(bits)) & 64'hFFFF_FFFF) / 64'd8;
      brate = prod[31:0];
      align = 16'((32'(ch) * 32'(bits)) / 32'd8);
      if (!sound) begin
         case ($urandom_range(0, 3))
            0: brate = brate ^ (32'd1 << $urandom_range(0, 31));
            1: align = align ^ (16'd1 << $urandom_range(0, 15));
            default: ;
         endcase
      end
      body = 32'd16;
      if ($urandom_range(0, 4) == 0) body = 32'd16 + $urandom_range(1, 6);
      if (!sound && $urandom_range(0, 3) == 0) body = $urandom_range(0, 15);
      put_le(TAG_FMT, 4);
      put_le(body, 4);
      if (body >= 32'd16) begin
         put_le(32'(fmt_code), 2);
         put_le(32'(ch), 2);
         put_le(rate, 4);
         put_le(brate, 4);
         put_le(32'(align), 2);
         put_le(32'(bits), 2);
         fill(body - 32'd16);
      end else begin
         fill(body);
      end
      if (body[0]) fill(1);
   endfunction

   function automatic void put_data(logic [31:0] len);
      put_le(TAG_DATA, 4);
      put_le(len, 4);
      fill(len);
      if (len[0]) fill(1);
   endfunction

   function automatic void put_other();
      logic [31:0] len;
      len = $urandom_range(0, 20);
      put_le($urandom_range(0, 1) ? 32'h5453_494C : $urandom, 4);
      put_le(len, 4);
      fill(len);
      if (len[0]) fill(1);
   endfunction

   // build one file image, return the length to program
   function automatic logic [31:0] build_wave();
      wave_shape_type shape;
      logic [31:0] flen, riff, big;
      img = {};
      put_le(TAG_RIFF, 4);
      put_le(32'd0, 4);
      put_le(TAG_WAVE, 4);
      shape = wave_shape_type'($urandom_range(0, 11) > 8 ? 0 : $urandom_range(0, 8));
      big = '0;
      case (shape)
         WF_DATA_FIRST: begin
            put_data($urandom_range(0, 16));
            put_fmt(1'b1);
         end
         WF_TWO_FMT: begin
            put_fmt(1'b1);
            put_fmt(1'b1);
            put_data($urandom_range(0, 16));
         end
         WF_TWO_DATA: begin
            put_fmt(1'b1);
            put_data($urandom_range(0, 8));
            put_data($urandom_range(0, 8));
         end
         WF_BAD_FMT: begin
            put_fmt(1'b0);
            put_data($urandom_range(0, 16));
         end
         WF_DATA_ONLY: begin
            put_data($urandom_range(0, 40));
         end
         WF_FMT_ONLY: begin
            put_other();
            put_fmt(1'b1);
            put_other();
         end
         WF_HUGE_DATA: begin
            put_fmt(1'b1);
            big = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFD2 : ($urandom & 32'h7FFF_FFFF);
            put_le(TAG_DATA, 4);
            put_le(big, 4);
         end
         WF_EXTRA_CHUNKS: begin
            put_other();
            put_fmt(1'b1);
            put_other();
            put_data($urandom_range(0, 16));
            put_other();
         end
         default: begin
            put_fmt(1'b1);
            put_data($urandom_range(0, 16));
         end
      endcase
      flen = 32'(img.size());
      if (shape == WF_HUGE_DATA) flen = flen + big + 32'(big[0]);
      riff = flen - 32'd8;
      if (!flen[0] && $urandom_range(0, 3) == 0) riff = flen - 32'd9;
      for (int i = 0; i < 4; i++) img[4 + i] = riff[8*i +: 8];
      if ($urandom_range(0, 6) == 0) begin
         img[$urandom_range(0, img.size() - 1)] ^= 8'(1 << $urandom_range(0, 7));
      end
      case ($urandom_range(0, 19))
         0: flen = $urandom_range(0, 43);
         1: flen = $urandom;
         2, 3: flen = flen + $urandom_range(0, 6) - 32'd3;
         default: ;
      endcase
      return flen;
   endfunction

   // hold until every item is in and every verdict is out
   task automatic settle();
      while (bytes_taken != bytes_queued || verdict_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_file_len(logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [31:0] flen;
      int unsigned n;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.file_start = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // stray bytes before any file, then too-short lengths
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_byte(8'hA5, 1'b0);
      settle();
      queue_byte(8'hFF, 1'b1);
      queue_byte(8'h00, 1'b0);
      settle();
      write_file_len(32'd43);
      queue_byte(8'h52, 1'b1);
      settle();
      write_file_len(32'hFFFF_FFFF);
      img = {};
      put_le(TAG_RIFF, 4);
      put_le(32'hFFFF_FFF7, 4);
      put_le(TAG_WAVE, 4);
      queue_file(12);

      while (bytes_queued < ITEM_TARGET) begin
         flen = build_wave();
         settle();
         write_file_len(flen);
         if ($urandom_range(0, 6) == 0) queue_file($urandom_range(1, img.size() - 1));
         n = img.size();
         if ($urandom_range(0, 9) == 0) n = $urandom_range(1, img.size() - 1);
         queue_file(n);
         if ($urandom_range(0, 3) == 0) queue_file(img.size());
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 8)) queue_byte(8'($urandom), 1'b0);
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
